[sv/rcpv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpv_pkg
// Shared constants and types for the RTCP compound packet validator.
// ----------------------------------------------------------------------------
package rcpv_pkg;

    localparam int unsigned BODY_W = 19;

    localparam logic [1:0] VERSION_RTP = 2'd2;
    localparam logic [1:0] VERSION_ALT = 2'd1;
    localparam logic [7:0] PAD_BIT     = 8'h20;
    localparam logic [7:0] TYPE_SR     = 8'd200;
    localparam logic [7:0] TYPE_RR     = 8'd201;
    localparam logic [7:0] TYPE_BYE    = 8'd203;

    // position of a byte within a subpacket header
    localparam logic [1:0] HDR_FLAGS   = 2'd0;
    localparam logic [1:0] HDR_TYPE    = 2'd1;
    localparam logic [1:0] HDR_LEN_HI  = 2'd2;
    localparam logic [1:0] HDR_LEN_LO  = 2'd3;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic packet_valid;
        logic has_bye;
    } t_result;

endpackage : rcpv_pkg
`default_nettype wire

[sv/rcpv_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpv_in_if
// Byte request channel: one packet byte and its end-of-packet mark.
// ----------------------------------------------------------------------------
interface rcpv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface : rcpv_in_if
`default_nettype wire

[sv/rcpv_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpv_out_if
// Verdict channel: one request per compound packet.
// ----------------------------------------------------------------------------
interface rcpv_out_if;
    logic valid;
    logic ready;
    logic packet_valid;
    logic has_bye;

    modport source (output valid, output packet_valid, output has_bye, input ready);
    modport sink   (input valid, input packet_valid, input has_bye, output ready);
endinterface : rcpv_out_if
`default_nettype wire

[sv/rcpv_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcpv_parser
// Subpacket walker: header checks, body byte count and the verdict on the
// final byte of a packet.
// ----------------------------------------------------------------------------
module rcpv_parser
    import rcpv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire t_in_item i_item,
    output t_result       o_result
);

    logic [1:0]        r_hdr_idx,  n_hdr_idx;
    logic              r_in_hdr,   n_in_hdr;
    logic              r_first,    n_first;
    logic [7:0]        r_len_hi,   n_len_hi;
    logic [BODY_W-1:0] r_body_left, n_body_left;
    logic              r_err,      n_err;
    logic              r_bye,      n_bye;

    logic [1:0]        c_ver;
    logic [BODY_W-1:0] c_body_dec;
    logic [BODY_W-1:0] c_body_new;
    logic              c_boundary;
    logic              c_ok;

    assign c_ver      = i_item.packet_byte[7:6];
    assign c_body_dec = r_body_left - BODY_W'(1);
    assign c_body_new = {1'b0, r_len_hi, i_item.packet_byte, 2'b00};

    always_comb begin
        n_hdr_idx   = r_hdr_idx;
        n_in_hdr    = r_in_hdr;
        n_first     = r_first;
        n_len_hi    = r_len_hi;
        n_body_left = r_body_left;
        n_err       = r_err;
        n_bye       = r_bye;

        if (r_in_hdr) begin
            unique case (r_hdr_idx)
                HDR_FLAGS: begin
                    if (r_first) begin
                        if ((c_ver != VERSION_RTP && c_ver != VERSION_ALT) ||
                            (i_item.packet_byte & PAD_BIT) != 8'h00) begin
                            n_err = 1'b1;
                        end
                    end else if (c_ver != VERSION_RTP) begin
                        n_err = 1'b1;
                    end
                    n_hdr_idx = HDR_TYPE;
                end
                HDR_TYPE: begin
                    if (r_first && i_item.packet_byte != TYPE_SR &&
                        i_item.packet_byte != TYPE_RR) begin
                        n_err = 1'b1;
                    end
                    if (i_item.packet_byte == TYPE_BYE) begin
                        n_bye = 1'b1;
                    end
                    n_hdr_idx = HDR_LEN_HI;
                end
                HDR_LEN_HI: begin
                    n_len_hi  = i_item.packet_byte;
                    n_hdr_idx = HDR_LEN_LO;
                end
                default: begin
                    n_body_left = c_body_new;
                    n_first     = 1'b0;
                    n_hdr_idx   = HDR_FLAGS;
                    // zero length: no body, next byte opens a header
                    if (c_body_new != '0) begin
                        n_in_hdr = 1'b0;
                    end
                end
            endcase
        end else begin
            n_body_left = c_body_dec;
            if (c_body_dec == '0) begin
                n_in_hdr  = 1'b1;
                n_hdr_idx = HDR_FLAGS;
            end
        end
    end

    assign c_boundary = n_in_hdr && (n_hdr_idx == HDR_FLAGS) && !n_first;
    assign c_ok       = c_boundary && !n_err;

    always_comb begin
        o_result.packet_valid = c_ok;
        o_result.has_bye      = c_ok && n_bye;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx   <= HDR_FLAGS;
            r_in_hdr    <= 1'b1;
            r_first     <= 1'b1;
            r_len_hi    <= '0;
            r_body_left <= '0;
            r_err       <= 1'b0;
            r_bye       <= 1'b0;
        end else if (i_fire) begin
            if (i_item.last_byte) begin
                // clear for the next packet
                r_hdr_idx   <= HDR_FLAGS;
                r_in_hdr    <= 1'b1;
                r_first     <= 1'b1;
                r_len_hi    <= '0;
                r_body_left <= '0;
                r_err       <= 1'b0;
                r_bye       <= 1'b0;
            end else begin
                r_hdr_idx   <= n_hdr_idx;
                r_in_hdr    <= n_in_hdr;
                r_first     <= n_first;
                r_len_hi    <= n_len_hi;
                r_body_left <= n_body_left;
                r_err       <= n_err;
                r_bye       <= n_bye;
            end
        end
    end

endmodule : rcpv_parser
`default_nettype wire

[sv/rtcp_compound_packet_validator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtcp_compound_packet_validator_unit
// Checks compound RTCP packets byte by byte and reports one verdict each.
//
// i_in carries one packet byte per request, last_byte set on the final byte.
// o_out carries one verdict per packet (packet_valid, has_bye), issued for
// the request that held the final byte.
// A byte lands in an input register and is parsed from there; if it ends a
// packet, its verdict is loaded into the output register that drives o_out.
// One byte is taken every cycle unless a final byte waits for the verdict
// slot; the rate is set by the single parse step per byte.
// Reset returns the parser to the start of a packet and empties both
// registers. When o_out stalls with a verdict held, bytes that end no packet
// still flow; a final byte waits in the input register until the verdict
// slot frees, and i_in.ready drops while it waits.
// ----------------------------------------------------------------------------
module rtcp_compound_packet_validator_unit
    import rcpv_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rcpv_in_if.sink   i_in,
    rcpv_out_if.source o_out
);

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    t_result  r_out;

    logic     c_out_free;
    logic     c_fire;
    t_result  c_result;

    assign c_out_free = !r_out_valid || o_out.ready;
    // a byte that ends no packet never needs the output slot
    assign c_fire     = r_in_valid && (!r_in_item.last_byte || c_out_free);
    assign i_in.ready = !r_in_valid || c_fire;

    rcpv_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (c_fire),
        .i_item   (r_in_item),
        .o_result (c_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item.packet_byte <= i_in.packet_byte;
            r_in_item.last_byte   <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_fire && r_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_fire && r_in_item.last_byte) begin
            r_out <= c_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.packet_valid = r_out.packet_valid;
    assign o_out.has_bye      = r_out.has_bye;

endmodule : rtcp_compound_packet_validator_unit
`default_nettype wire

[test/rtcp_compound_packet_validator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcp_compound_packet_validator_unit_tb
// Streams compound RTCP packets through the byte channel, one byte per
// request. An in-bench parser follows the same header and length rules to
// work out each packet's verdict. Every verdict on the output channel is
// checked against the oldest outstanding one. Both channels stall at random in the first two phases.
// ----------------------------------------------------------------------------
module rtcp_compound_packet_validator_unit_tb;
    import rcpv_pkg::*;

    localparam logic [7:0] TYPE_SDES = 8'd202;

    typedef enum int {
        CUT_SHORT,
        RUN_LONG,
        BAD_LEAD_VERSION,
        LEAD_PADDED,
        BAD_LEAD_TYPE,
        BAD_LATER_VERSION,
        GARBAGE,
        HUGE_LENGTH
    } t_flaw;

    logic i_clk;
    logic i_rst_n;

    rcpv_in_if  in_bus ();
    rcpv_out_if out_bus ();

    rtcp_compound_packet_validator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_in_item   pending_bytes[$];
    t_result    verdicts_due[$];
    logic [7:0] pkt[$];
    int         hdr_at[$];
    int         src_idle_pct;
    int         snk_idle_pct;
    int         mismatches;
    bit         in_fire;

    // parser state
    logic [1:0]        hdr_pos;
    bit                in_hdr;
    bit                first_sub;
    logic [7:0]        len_hi;
    logic [BODY_W-1:0] body_left;
    bit                rule_broken;
    bit                bye_seen;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void clear_parser();
        hdr_pos     = HDR_FLAGS;
        in_hdr      = 1'b1;
        first_sub   = 1'b1;
        len_hi      = 8'h00;
        body_left   = '0;
        rule_broken = 1'b0;
        bye_seen    = 1'b0;
    endfunction

    // Advance the parser by one byte; on the final byte queue the verdict.
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        logic [15:0] len;
        t_result     verdict;
        if (in_hdr) begin
            case (hdr_pos)
                HDR_FLAGS: begin
                    if (first_sub) begin
                        if ((b[7:6] != VERSION_RTP && b[7:6] != VERSION_ALT)
                                || (b & PAD_BIT) != 8'h00)
                            rule_broken = 1'b1;
                    end else if (b[7:6] != VERSION_RTP) begin
                        rule_broken = 1'b1;
                    end
                    hdr_pos = HDR_TYPE;
                end
                HDR_TYPE: begin
                    if (first_sub && b != TYPE_SR && b != TYPE_RR)
                        rule_broken = 1'b1;
                    if (b == TYPE_BYE)
                        bye_seen = 1'b1;
                    hdr_pos = HDR_LEN_HI;
                end
                HDR_LEN_HI: begin
                    len_hi  = b;
                    hdr_pos = HDR_LEN_LO;
                end
                default: begin
                    len       = {len_hi, b};
                    body_left = {1'b0, len, 2'b00};
                    first_sub = 1'b0;
                    hdr_pos   = HDR_FLAGS;
                    // a zero length word has no body: stay on headers
                    if (body_left != '0)
                        in_hdr = 1'b0;
                end
            endcase
        end else begin
            body_left = body_left - 1'b1;
            if (body_left == '0) begin
                in_hdr  = 1'b1;
                hdr_pos = HDR_FLAGS;
            end
        end
        if (last) begin
            verdict.packet_valid = in_hdr && hdr_pos == HDR_FLAGS && !first_sub
                                   && !rule_broken;
            verdict.has_bye      = verdict.packet_valid && bye_seen;
            verdicts_due.push_back(verdict);
            clear_parser();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [7:0] pick_kind();
        case ($urandom_range(5))
            0:       return TYPE_SR;
            1:       return TYPE_RR;
            2:       return TYPE_BYE;
            3:       return TYPE_BYE;
            4:       return TYPE_SDES;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_subpacket(input bit lead, input logic [15:0] words,
                                          input logic [7:0] kind);
        logic [7:0] noise;
        noise = 8'($urandom);
        hdr_at.push_back(pkt.size());
        if (lead)
            pkt.push_back({($urandom_range(1) == 1) ? VERSION_RTP : VERSION_ALT,
                           1'b0, noise[4:0]});
        else
            pkt.push_back({VERSION_RTP, noise[5:0]});
        pkt.push_back(kind);
        pkt.push_back(words[15:8]);
        pkt.push_back(words[7:0]);
        for (int i = 0; i < 4 * int'(words); i++)
            pkt.push_back(8'($urandom));
    endfunction

    function automatic void queue_packet();
        t_in_item it;
        foreach (pkt[i]) begin
            it.packet_byte = pkt[i];
            it.last_byte   = (i == pkt.size() - 1);
            pending_bytes.push_back(it);
        end
    endfunction

    // Build one packet, mostly well formed, sometimes damaged; return its size.
    function automatic int random_packet();
        int         subs;
        int         idx;
        logic [7:0] noise;
        logic [7:0] lead_kind;
        pkt.delete();
        hdr_at.delete();
        lead_kind = ($urandom_range(1) == 1) ? TYPE_SR : TYPE_RR;
        if ($urandom_range(29) == 0)
            add_subpacket(1'b1, 16'($urandom_range(20, 8)), lead_kind);
        else
            add_subpacket(1'b1, 16'($urandom_range(4)), lead_kind);
        subs = $urandom_range(3);
        for (int s = 0; s < subs; s++)
            add_subpacket(1'b0, 16'($urandom_range(3)), pick_kind());
        if ($urandom_range(99) < 35) begin
            case (t_flaw'($urandom_range(7)))
                CUT_SHORT: begin
                    repeat ($urandom_range(pkt.size() - 1, 1))
                        void'(pkt.pop_back());
                end
                RUN_LONG: begin
                    repeat ($urandom_range(5, 1))
                        pkt.push_back(8'($urandom));
                end
                BAD_LEAD_VERSION: begin
                    noise      = pkt[0];
                    noise[7:6] = ($urandom_range(1) == 1) ? 2'b11 : 2'b00;
                    pkt[0]     = noise;
                end
                LEAD_PADDED: begin
                    pkt[0] = pkt[0] | PAD_BIT;
                end
                BAD_LEAD_TYPE: begin
                    pkt[1] = ($urandom_range(3) == 0) ? TYPE_BYE : 8'($urandom);
                end
                BAD_LATER_VERSION: begin
                    if (hdr_at.size() > 1) begin
                        idx        = hdr_at[$urandom_range(hdr_at.size() - 1, 1)];
                        noise      = pkt[idx];
                        noise[7:6] = ($urandom_range(1) == 1) ? VERSION_ALT : 2'b11;
                        pkt[idx]   = noise;
                    end else begin
                        pkt[0] = pkt[0] | PAD_BIT;
                    end
                end
                GARBAGE: begin
                    pkt.delete();
                    repeat ($urandom_range(12, 1))
                        pkt.push_back(8'($urandom));
                end
                default: begin
                    // claim a huge body, then end the packet early
                    pkt[2] = 8'($urandom_range(255, 128));
                    while (pkt.size() > 4)
                        void'(pkt.pop_back());
                    repeat ($urandom_range(8))
                        pkt.push_back(8'($urandom));
                end
            endcase
        end
        queue_packet();
        return pkt.size();
    endfunction

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_bus.valid || verdicts_due.size() != 0)
            @(posedge i_clk);
    endtask

    // driver: present the next request after the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid  <= 1'b0;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
            if (!in_bus.valid || in_fire) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_bus.valid       <= 1'b1;
                    in_bus.packet_byte <= pending_bytes[0].packet_byte;
                    in_bus.last_byte   <= pending_bytes[0].last_byte;
                    void'(pending_bytes.pop_front());
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check verdicts first, then advance the parser on taken bytes
    always @(posedge i_clk) begin : watch
        t_result want;
        in_fire <= i_rst_n && in_bus.valid && in_bus.ready;
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected verdict valid=%0b bye=%0b",
                                              out_bus.packet_valid, out_bus.has_bye));
                end else begin
                    want = verdicts_due.pop_front();
                    if (out_bus.packet_valid !== want.packet_valid)
                        report_mismatch($sformatf("packet_valid got %0b want %0b",
                                                  out_bus.packet_valid, want.packet_valid));
                    if (out_bus.has_bye !== want.has_bye)
                        report_mismatch($sformatf("has_bye got %0b want %0b",
                                                  out_bus.has_bye, want.has_bye));
                end
            end
            if (in_bus.valid && in_bus.ready)
                parse_byte(in_bus.packet_byte, in_bus.last_byte);
        end
    end

    initial begin
        int src_pct_by_phase [3];
        int snk_pct_by_phase [3];
        int made;
        src_pct_by_phase   = '{32, 64, 0};
        snk_pct_by_phase   = '{64, 32, 0};
        in_bus.valid       = 1'b0;
        in_bus.packet_byte = 8'h00;
        in_bus.last_byte   = 1'b0;
        out_bus.ready      = 1'b0;
        i_rst_n            = 1'b0;
        mismatches         = 0;
        src_idle_pct       = 0;
        snk_idle_pct       = 0;
        clear_parser();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = src_pct_by_phase[ph];
            snk_idle_pct = snk_pct_by_phase[ph];
            if (ph == 0) begin
                // packet cut inside the first header
                pkt = '{{VERSION_RTP, 6'd0}};
                queue_packet();
                // smallest valid packet: one empty receiver report
                pkt = '{{VERSION_RTP, 6'd0}, TYPE_RR, 8'h00, 8'h00};
                queue_packet();
                // alternate version sender report with a body, then an empty BYE
                pkt = '{{VERSION_ALT, 6'h1F}, TYPE_SR, 8'h00, 8'h01,
                        8'hFF, 8'h00, 8'hAA, 8'h55,
                        {VERSION_RTP, 6'h3F}, TYPE_BYE, 8'h00, 8'h00};
                queue_packet();
                // padding set on the first header
                pkt = '{{VERSION_RTP, 6'h20}, TYPE_RR, 8'h00, 8'h00};
                queue_packet();
                // packet ends inside a body
                pkt = '{{VERSION_RTP, 6'd0}, TYPE_RR, 8'h00, 8'h01, 8'h12};
                queue_packet();
            end
            made = 0;
            while (made < 130)
                made += random_packet();
            if (ph == 2) begin
                // one long report to walk the wide body counter
                pkt.delete();
                hdr_at.delete();
                add_subpacket(1'b1, 16'(64 + $urandom_range(3)), TYPE_RR);
                add_subpacket(1'b0, 16'd0, TYPE_BYE);
                queue_packet();
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("rtcp_compound_packet_validator_unit: match");
        else
            $display("rtcp_compound_packet_validator_unit: mismatch");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("rtcp_compound_packet_validator_unit: mismatch");
        $finish;
    end

endmodule
